>>> rtl/iaids_pkg.sv
// Package for the indexed array insert/delete/search unit.
// Holds the command and status codes, the payload structs and the cell control struct.
// No dependencies.
package iaids_pkg;

  // Number of cells. The fixed field widths below are sized for this capacity.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned CountW   = $clog2(CAPACITY + 1);
  localparam int unsigned ValueW   = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_WRITE = 2'd1,
    CELL_OPEN  = 2'd2,
    CELL_CLOSE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [4:0]               position;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] found_position;
    logic [4:0] count_now;
  } res_t;

  // Broadcast from the controller to the row of cells.
  typedef struct packed {
    cell_op_e                 op;
    logic [CountW-1:0]        pos;
    logic [CountW-1:0]        count;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

>>> rtl/iaids_cell.sv
// One storage cell of the list: holds one word and shifts with its neighbors.
// Also compares its word against the broadcast search word.
// Depends on iaids_pkg.
module iaids_cell (
  input  logic                                clk_i,
  input  logic [iaids_pkg::IdxW-1:0]          index_i,
  input  iaids_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [iaids_pkg::ValueW-1:0] left_i,
  input  logic signed [iaids_pkg::ValueW-1:0] right_i,
  output logic signed [iaids_pkg::ValueW-1:0] value_o,
  output logic                                match_o
);

  logic signed [iaids_pkg::ValueW-1:0] value_q, value_d;
  logic [iaids_pkg::CountW-1:0]        idx_w;

  assign idx_w = iaids_pkg::CountW'(index_i);

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      iaids_pkg::CELL_WRITE: begin
        if (idx_w == ctrl_i.pos) value_d = ctrl_i.value;
      end
      iaids_pkg::CELL_OPEN: begin
        // Cells past the insert point take the word from below.
        if (idx_w > ctrl_i.pos) value_d = left_i;
        else if (idx_w == ctrl_i.pos) value_d = ctrl_i.value;
      end
      iaids_pkg::CELL_CLOSE: begin
        if (idx_w >= ctrl_i.pos) value_d = right_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (value_q == ctrl_i.value) && (idx_w < ctrl_i.count);

endmodule

>>> rtl/indexed_array_insert_delete_search_unit.sv
// The result word of an accepted command is registered and shows in the cycle after it is accepted.
// Throughput: one command per cycle while result words are taken; all cells shift or compare in parallel.
// A new command enters only when the output register is empty or its word is taken that cycle.
// Reset clears the entry count and the output valid; cell contents stay undefined.
// Depends on iaids_pkg and iaids_cell.
module indexed_array_insert_delete_search_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  iaids_pkg::cmd_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output iaids_pkg::res_t   out_data_o
);

  localparam int unsigned N = iaids_pkg::CAPACITY;

  logic [iaids_pkg::CountW-1:0]        count_q, count_d;
  logic                                out_valid_q;
  iaids_pkg::res_t                     out_data_q, res_w;
  iaids_pkg::cell_ctrl_t               ctrl_w;
  iaids_pkg::cell_op_e                 op_w;
  logic [iaids_pkg::CountW-1:0]        pos_w;
  logic signed [iaids_pkg::ValueW-1:0] vals_w [N];
  logic [N-1:0]                        match_w;
  logic [iaids_pkg::IdxW-1:0]          first_w;
  logic                                accept_w, full_w;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept_w   = in_valid_i && in_ready_o;
  assign full_w     = (count_q == iaids_pkg::CountW'(N));

  // Lowest matching cell wins.
  always_comb begin
    first_w = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_w[i]) first_w = iaids_pkg::IdxW'(i);
    end
  end

  always_comb begin
    op_w                 = iaids_pkg::CELL_HOLD;
    pos_w                = in_data_i.position;
    count_d              = count_q;
    res_w.status         = iaids_pkg::ST_OK;
    res_w.found_position = '0;
    case (in_data_i.cmd)
      iaids_pkg::CMD_APPEND: begin
        if (full_w) begin
          res_w.status = iaids_pkg::ST_FULL;
        end else begin
          op_w    = iaids_pkg::CELL_WRITE;
          pos_w   = count_q;
          count_d = count_q + 1'b1;
        end
      end
      iaids_pkg::CMD_INSERT: begin
        if (full_w) begin
          res_w.status = iaids_pkg::ST_FULL;
        end else if (in_data_i.position > count_q) begin
          res_w.status = iaids_pkg::ST_BADPOS;
        end else begin
          op_w    = iaids_pkg::CELL_OPEN;
          count_d = count_q + 1'b1;
        end
      end
      iaids_pkg::CMD_DELETE: begin
        if (in_data_i.position >= count_q) begin
          res_w.status = iaids_pkg::ST_BADPOS;
        end else begin
          op_w    = iaids_pkg::CELL_CLOSE;
          count_d = count_q - 1'b1;
        end
      end
      iaids_pkg::CMD_SEARCH: begin
        if (|match_w) res_w.found_position = 4'(first_w);
        else          res_w.status = iaids_pkg::ST_NOTFOUND;
      end
      default: op_w = iaids_pkg::CELL_HOLD;
    endcase
    res_w.count_now = 5'(count_d);
  end

  assign ctrl_w.op    = accept_w ? op_w : iaids_pkg::CELL_HOLD;
  assign ctrl_w.pos   = pos_w;
  assign ctrl_w.count = count_q;
  assign ctrl_w.value = in_data_i.value;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [iaids_pkg::ValueW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = in_data_i.value;
    end else begin : g_mid_l
      assign left_w = vals_w[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_w = vals_w[g];
    end else begin : g_mid_r
      assign right_w = vals_w[g+1];
    end
    iaids_cell u_cell (
      .clk_i   (clk_i),
      .index_i (iaids_pkg::IdxW'(g)),
      .ctrl_i  (ctrl_w),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (vals_w[g]),
      .match_o (match_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_w) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) out_data_q <= res_w;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/iaids_chk.sv
// Port-level checker for the indexed array insert/delete/search unit, with its bind.
// Depends on iaids_pkg and indexed_array_insert_delete_search_unit.
module iaids_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input iaids_pkg::res_t out_data_o
);

  // A result word waits, unchanged, until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // Every accepted command gives a result word in the next cycle.
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result one cycle after an accepted command");

  // With nothing waiting at the output, the unit takes commands.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output");

  // Only a result with status OK may report a nonzero position, and the count stays in range.
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.count_now <= 5'(iaids_pkg::CAPACITY)) &&
                    (out_data_o.status == iaids_pkg::ST_OK ||
                     out_data_o.found_position == 4'd0))
    else $error("result fields out of range");

endmodule

bind indexed_array_insert_delete_search_unit iaids_chk u_iaids_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
